@@ rtl/sfc_pkg.sv @@
// Shared types, constants and the CRC-32C byte step for the snapshot frame checker.
// No dependencies.
`default_nettype none

package sfc_pkg;

  localparam int unsigned POSITION_BITS = 40;
  localparam int unsigned OUT_DEPTH     = 4;

  localparam int unsigned HDR_BYTES     = 32;
  localparam int unsigned FTR_BYTES     = 16;
  localparam int unsigned HDR_CRC_SPAN  = 28;
  localparam int unsigned FTR_CRC_SPAN  = 12;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  typedef enum logic [1:0] {
    CFG_HEADER_MAGIC     = 2'd0,
    CFG_FOOTER_MAGIC     = 2'd1,
    CFG_EXPECTED_VERSION = 2'd2,
    CFG_MAX_PAYLOAD      = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_OK              = 4'd0,
    ST_TRUNCATED       = 4'd1,
    ST_BAD_MAGIC       = 4'd2,
    ST_HEADER_CRC      = 4'd3,
    ST_VERSION         = 4'd4,
    ST_OVERSIZE        = 4'd5,
    ST_LENGTH_MISMATCH = 4'd6,
    ST_PAYLOAD_CRC     = 4'd7,
    ST_FOOTER_MAGIC    = 4'd8,
    ST_FOOTER_VERSION  = 4'd9,
    ST_CRC_DISAGREE    = 4'd10,
    ST_FOOTER_CRC      = 4'd11
  } status_e;

  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [63:0] sequence_out;
    logic [63:0] length_out;
    logic [31:0] payload_crc_out;
  } result_t;

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/snapshot_frame_checker.sv @@
// Snapshot frame checker: byte-wide CRC-32C frame validator with payload forwarding.
// Depends on sfc_pkg (constants, status codes, result type, CRC byte step).
//
// Takes one frame byte per cycle; every byte is handled in the cycle it is accepted,
// and its result beats enter a four-entry output queue visible the next cycle. A payload
// byte gives one forwarded beat, the final byte gives a verdict beat (after the forwarded
// beat when the final byte is itself payload). Input ready drops only when the queue
// holds more than two beats, so the rate is one byte per cycle while the consumer keeps up.
`default_nettype none

module snapshot_frame_checker #(
  parameter int unsigned POSITION_BITS = sfc_pkg::POSITION_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                frame_end_i,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic                is_verdict_o,
  output      logic [7:0]          payload_byte_o,
  output      logic [3:0]          status_o,
  output      logic [63:0]         sequence_out_o,
  output      logic [63:0]         length_out_o,
  output      logic [31:0]         payload_crc_out_o
);

  localparam int unsigned P        = POSITION_BITS;
  localparam int unsigned DEPTH    = sfc_pkg::OUT_DEPTH;
  localparam int unsigned PTR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned HB       = sfc_pkg::HDR_BYTES;
  localparam int unsigned FB       = sfc_pkg::FTR_BYTES;
  localparam int unsigned HIDX_W   = $clog2(HB);
  localparam int unsigned MIN_LEN  = sfc_pkg::HDR_BYTES + sfc_pkg::FTR_BYTES;

  logic [31:0] hdr_magic_q, ftr_magic_q, version_q, max_payload_q;

  logic [P-1:0]  pos_q, pos_d;
  logic [31:0]   crc_q, crc_d;
  logic [7:0]    hdr_q [HB];
  logic [7:0]    hdr_d [HB];
  logic [7:0]    ftr_q [FB];
  logic [7:0]    ftr_d [FB];
  logic          good_q, good_d;
  logic [31:0]   pcrc_q, pcrc_d;
  logic [31:0]   fcrc_q, fcrc_d;

  logic [31:0]   hw_q [HB/4];
  logic [31:0]   hw_d [HB/4];
  logic [31:0]   fw_d [FB/4];

  logic          in_acc, last, sat, in_hdr, fwd;
  logic [P-1:0]  rel, total;
  logic [64:0]   diff, len_sum;
  logic [63:0]   len_q, len_d;
  logic [31:0]   crc_step, fcrc_step;
  sfc_pkg::status_e status;

  sfc_pkg::result_t fifo_q [DEPTH];
  sfc_pkg::result_t fwd_res, ver_res, e0;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_nxt;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push0, push1, pop;
  logic [1:0]       n_push;
  sfc_pkg::result_t head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_magic_q   <= '0;
      ftr_magic_q   <= '0;
      version_q     <= '0;
      max_payload_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (sfc_pkg::cfg_reg_e'(cfg_index_i))
        sfc_pkg::CFG_HEADER_MAGIC:     hdr_magic_q   <= cfg_data_i;
        sfc_pkg::CFG_FOOTER_MAGIC:     ftr_magic_q   <= cfg_data_i;
        sfc_pkg::CFG_EXPECTED_VERSION: version_q     <= cfg_data_i;
        sfc_pkg::CFG_MAX_PAYLOAD:      max_payload_q <= cfg_data_i;
      endcase
    end
  end

  assign in_ready_o = cnt_q <= CNT_W'(DEPTH - 2);
  assign in_acc     = in_valid_i & in_ready_o;
  assign last       = in_acc & frame_end_i;

  always_comb begin
    for (int k = 0; k < HB / 4; k++) begin
      hw_q[k] = {hdr_q[4*k+3], hdr_q[4*k+2], hdr_q[4*k+1], hdr_q[4*k]};
    end
  end
  assign len_q = {hw_q[5], hw_q[4]};

  assign sat       = &pos_q;
  assign in_hdr    = pos_q < P'(HB);
  assign rel       = pos_q - P'(HB);
  assign diff      = 65'(rel) - 65'(len_q);
  assign total     = pos_q + P'(1);
  assign crc_step  = sfc_pkg::crc32c_byte(crc_q, data_byte_i);
  assign fcrc_step = sfc_pkg::crc32c_byte(fcrc_q, data_byte_i);

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    hdr_d  = hdr_q;
    ftr_d  = ftr_q;
    good_d = good_q;
    pcrc_d = pcrc_q;
    fcrc_d = fcrc_q;
    fwd    = 1'b0;
    if (in_acc) begin
      if (!sat) begin
        if (in_hdr) begin
          hdr_d[pos_q[HIDX_W-1:0]] = data_byte_i;
          if (pos_q < P'(sfc_pkg::HDR_CRC_SPAN)) begin
            crc_d = crc_step;
          end
          if (pos_q == P'(HB - 1)) begin
            good_d = (~crc_q) == {data_byte_i, hdr_q[HB-2], hdr_q[HB-3], hdr_q[HB-4]};
            crc_d  = '1;
            pcrc_d = '0;
            fcrc_d = '1;
          end
        end else if (diff[64]) begin
          crc_d  = crc_step;
          pcrc_d = ~crc_step;
          fwd    = 1'b1;
        end else if (diff[63:0] < 64'(sfc_pkg::FTR_CRC_SPAN)) begin
          fcrc_d = fcrc_step;
        end
        pos_d = total;
      end
      for (int k = 0; k < FB - 1; k++) begin
        ftr_d[k] = ftr_q[k+1];
      end
      ftr_d[FB-1] = data_byte_i;
    end

    for (int k = 0; k < HB / 4; k++) begin
      hw_d[k] = {hdr_d[4*k+3], hdr_d[4*k+2], hdr_d[4*k+1], hdr_d[4*k]};
    end
    for (int k = 0; k < FB / 4; k++) begin
      fw_d[k] = {ftr_d[4*k+3], ftr_d[4*k+2], ftr_d[4*k+1], ftr_d[4*k]};
    end
    len_d   = {hw_d[5], hw_d[4]};
    len_sum = 65'(len_d) + 65'(MIN_LEN);

    priority if (!sat && total < P'(MIN_LEN))         status = sfc_pkg::ST_TRUNCATED;
    else if (hw_d[0] != hdr_magic_q)                  status = sfc_pkg::ST_BAD_MAGIC;
    else if (!good_d)                                 status = sfc_pkg::ST_HEADER_CRC;
    else if (hw_d[1] != version_q)                    status = sfc_pkg::ST_VERSION;
    else if (len_d > 64'(max_payload_q))              status = sfc_pkg::ST_OVERSIZE;
    else if (sat || len_sum != 65'(total))            status = sfc_pkg::ST_LENGTH_MISMATCH;
    else if (pcrc_d != hw_d[6])                       status = sfc_pkg::ST_PAYLOAD_CRC;
    else if (fw_d[0] != ftr_magic_q)                  status = sfc_pkg::ST_FOOTER_MAGIC;
    else if (fw_d[1] != version_q)                    status = sfc_pkg::ST_FOOTER_VERSION;
    else if (fw_d[2] != hw_d[6])                      status = sfc_pkg::ST_CRC_DISAGREE;
    else if (fw_d[3] != ~fcrc_d)                      status = sfc_pkg::ST_FOOTER_CRC;
    else                                              status = sfc_pkg::ST_OK;

    fwd_res                 = '0;
    fwd_res.payload_byte    = data_byte_i;
    fwd_res.status          = sfc_pkg::ST_OK;
    ver_res                 = '0;
    ver_res.is_verdict      = 1'b1;
    ver_res.status          = status;
    ver_res.sequence_out    = {hw_d[3], hw_d[2]};
    ver_res.length_out      = len_d;
    ver_res.payload_crc_out = hw_d[6];

    // drop all frame state when the final byte is accepted and its verdict is queued
    if (last) begin
      pos_d  = '0;
      crc_d  = '1;
      good_d = 1'b0;
      pcrc_d = '0;
      fcrc_d = '0;
      for (int k = 0; k < HB; k++) begin
        hdr_d[k] = '0;
      end
      for (int k = 0; k < FB; k++) begin
        ftr_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= '1;
      good_q <= 1'b0;
      pcrc_q <= '0;
      fcrc_q <= '0;
      for (int k = 0; k < HB; k++) begin
        hdr_q[k] <= '0;
      end
      for (int k = 0; k < FB; k++) begin
        ftr_q[k] <= '0;
      end
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      good_q <= good_d;
      pcrc_q <= pcrc_d;
      fcrc_q <= fcrc_d;
      hdr_q  <= hdr_d;
      ftr_q  <= ftr_d;
    end
  end

  // output queue: up to two beats in, one beat out per cycle
  assign push0  = fwd | last;
  assign push1  = fwd & last;
  assign e0     = fwd ? fwd_res : ver_res;
  assign n_push = {1'b0, push0} + {1'b0, push1};
  assign wr_nxt = wr_ptr_q + PTR_W'(1);
  assign pop    = out_valid_o & out_ready_i;
  assign cnt_d  = cnt_q + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push0) begin
      fifo_q[wr_ptr_q] <= e0;
    end
    if (push1) begin
      fifo_q[wr_nxt] <= ver_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      cnt_q    <= cnt_d;
    end
  end

  assign head              = fifo_q[rd_ptr_q];
  assign out_valid_o       = cnt_q != '0;
  assign is_verdict_o      = head.is_verdict;
  assign payload_byte_o    = head.payload_byte;
  assign status_o          = head.status;
  assign sequence_out_o    = head.sequence_out;
  assign length_out_o      = head.length_out;
  assign payload_crc_out_o = head.payload_crc_out;

endmodule

`default_nettype wire
